>>> rtl/core/assert_macros.svh
// Assertion macros shared by the decimal-to-LCD byte stream RTL.
// Every macro expects clk_i and rst_ni in the scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DLB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be true outside reset.
`define DLB_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> rtl/core/dlb_pkg.sv
// Package for the decimal-to-LCD byte stream: byte codes, types, divide-by-ten helper.
// No dependencies; imported by dlb_front, dlb_fifo, dlb_back and the top level.
package dlb_pkg;

  localparam int unsigned ValW      = 16;
  localparam int unsigned MaxDigits = 5;
  localparam int unsigned DigCntW   = 3;  // holds 0..MaxDigits
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  // Byte codes
  localparam logic [7:0] LcdClear  = 8'h01;
  localparam logic [7:0] LcdHome   = 8'h80;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharR     = 8'h52;
  localparam logic [7:0] CharP     = 8'h50;
  localparam logic [7:0] CharM     = 8'h4D;
  localparam logic [7:0] CharZero  = 8'h30;

  // ceil(2^19 / 10): exact quotient for every 16-bit value
  localparam logic [31:0] Recip10 = 32'd52429;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CLR,
    B_HOME,
    B_DIGIT,
    B_SPACE,
    B_R,
    B_P,
    B_M
  } back_state_e;

  // One queued job: digits least significant first, plus digit count
  typedef struct packed {
    logic [MaxDigits-1:0][3:0] digs;
    logic [DigCntW-1:0]        ndig;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [ValW-1:0] div10(input logic [ValW-1:0] v);
    logic [31:0] p;
    p = 32'(v) * Recip10;
    return ValW'(p[31:19]);
  endfunction

endpackage

>>> rtl/core/decimal_value_to_lcd_bytes_top.sv
// With n decimal digits (1..5), the first byte is strobed once the front end has split the
// value and queued the job, the back end has popped it and its byte register has loaded it;
// the sequence is 6+n bytes on consecutive cycles (7 to 11). Sustained throughput is set by
// the one-byte-per-cycle back end, and busy drops once a job is queued.
// Reset (rst_ni, async, active low) empties the queue and idles both ends; no result
// is lost to the receiver since it cannot stall: every strobe is a transfer.
//
// Dependencies: dlb_pkg, dlb_front, dlb_fifo, dlb_back.

module decimal_value_to_lcd_bytes_top import dlb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Command side: a transfer happens when start is high and busy is low
  input  logic            start,
  input  logic [ValW-1:0] rpm_value_i,
  output logic            busy,
  // Result side: one byte per strobe cycle, no back-pressure
  output logic            strobe_o,
  output logic [7:0]      lcd_byte_o,
  output logic            is_data_o,
  output logic            last_byte_o
);

  // Front end splits the value into digits (one divide-by-ten per cycle)
  // and hands a job record to the queue; the back end then walks the
  // fixed byte sequence: clear, home, digits MS first, space, R, P, M.
  fifo_stat_t q_stat;
  rec_t       q_wdata, q_rdata;
  logic       q_push, q_pop;

  dlb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .rpm_value_i (rpm_value_i),
    .stat_i      (q_stat),
    .busy_o      (busy),
    .push_o      (q_push),
    .rec_o       (q_wdata)
  );

  // Two-entry queue lets the front convert the next value while the back
  // is still streaming the previous sequence.
  dlb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  // Back end pops a job right at the final byte of the prior one, so
  // sequences run gap-free while jobs are waiting.
  dlb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (q_stat),
    .rec_i       (q_rdata),
    .pop_o       (q_pop),
    .strobe_o    (strobe_o),
    .lcd_byte_o  (lcd_byte_o),
    .is_data_o   (is_data_o),
    .last_byte_o (last_byte_o)
  );

endmodule

>>> rtl/core/dlb_front.sv
// Front end: takes a 16-bit value and splits it into decimal digits, one per cycle.
// Depends on dlb_pkg and assert_macros.svh; pushes finished jobs into dlb_fifo.
`include "assert_macros.svh"

module dlb_front import dlb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [ValW-1:0] rpm_value_i,
  input  fifo_stat_t      stat_i,
  output logic            busy_o,
  output logic            push_o,
  output rec_t            rec_o
);

  front_state_e state_q, state_d;
  logic [DigCntW-1:0]        cnt_q;
  logic [ValW-1:0]           v_q;
  logic [MaxDigits-1:0][3:0] digs_q;
  logic [ValW-1:0]           quo;
  logic [ValW-1:0]           rem_w;

  assign quo   = div10(v_q);
  assign rem_w = v_q - (quo << 3) - (quo << 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (start_i) state_d = F_CONV;
      F_CONV: if (quo == '0) state_d = F_PUSH;
      F_PUSH: if (!stat_i.full) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q != F_IDLE);
    push_o = (state_q == F_PUSH) && !stat_i.full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_IDLE && start_i) begin
        cnt_q <= '0;
      end else if (state_q == F_CONV) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && start_i) begin
      v_q <= rpm_value_i;
    end else if (state_q == F_CONV) begin
      v_q            <= quo;
      digs_q[cnt_q]  <= rem_w[3:0];
    end
  end

  assign rec_o.digs = digs_q;
  assign rec_o.ndig = cnt_q;

  `DLB_ASSERT(a_conv_cnt_range, (state_q == F_CONV) |-> (cnt_q < DigCntW'(MaxDigits)), "digit counter past last digit")
  `DLB_ASSERT(a_push_value_done, (state_q == F_PUSH) |-> (v_q == '0), "job queued before value fully split")

endmodule

>>> rtl/core/dlb_fifo.sv
// Short job queue between front and back ends, register based.
// Depends on dlb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dlb_fifo import dlb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  rec_t       wdata_i,
  input  logic       pop_i,
  output rec_t       rdata_o,
  output fifo_stat_t stat_o
);

  rec_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign rdata_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  `DLB_ASSERT_NEVER(a_cnt_ovf, cnt_q > QCntW'(QDepth), "queue count above depth")

endmodule

>>> rtl/core/dlb_back.sv
// Back end: sequencer that emits one LCD byte per cycle for each queued job.
// Depends on dlb_pkg and assert_macros.svh; pops jobs from dlb_fifo.
`include "assert_macros.svh"

module dlb_back import dlb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fifo_stat_t stat_i,
  input  rec_t       rec_i,
  output logic       pop_o,
  output logic       strobe_o,
  output logic [7:0] lcd_byte_o,
  output logic       is_data_o,
  output logic       last_byte_o
);

  back_state_e state_q, state_d;
  rec_t               rec_q;
  logic [DigCntW-1:0] idx_q;
  logic               strobe_q, strobe_d;
  logic [7:0]         byte_q, byte_d;
  logic               data_q, data_d;
  logic               last_q, last_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (!stat_i.empty) state_d = B_CLR;
      B_CLR:   state_d = B_HOME;
      B_HOME:  state_d = B_DIGIT;
      B_DIGIT: if (idx_q == '0) state_d = B_SPACE;
      B_SPACE: state_d = B_R;
      B_R:     state_d = B_P;
      B_P:     state_d = B_M;
      B_M:     state_d = stat_i.empty ? B_IDLE : B_CLR;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    strobe_d = 1'b1;
    byte_d   = CharSpace;
    data_d   = 1'b1;
    last_d   = 1'b0;
    pop_o    = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        strobe_d = 1'b0;
        pop_o    = !stat_i.empty;
      end
      B_CLR: begin
        byte_d = LcdClear;
        data_d = 1'b0;
      end
      B_HOME: begin
        byte_d = LcdHome;
        data_d = 1'b0;
      end
      B_DIGIT: byte_d = CharZero + {4'b0, rec_q.digs[idx_q]};
      B_SPACE: byte_d = CharSpace;
      B_R:     byte_d = CharR;
      B_P:     byte_d = CharP;
      B_M: begin
        byte_d = CharM;
        last_d = 1'b1;
        pop_o  = !stat_i.empty;
      end
      default: strobe_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    data_q <= data_d;
    last_q <= last_d;
    if (pop_o) rec_q <= rec_i;
    if (state_q == B_HOME) begin
      idx_q <= rec_q.ndig - 1'b1;
    end else if (state_q == B_DIGIT) begin
      idx_q <= idx_q - 1'b1;
    end
  end

  assign strobe_o    = strobe_q;
  assign lcd_byte_o  = byte_q;
  assign is_data_o   = data_q;
  assign last_byte_o = last_q;

  `DLB_ASSERT(a_home_after_clear, (strobe_o && !is_data_o && (lcd_byte_o == LcdClear)) |=> (strobe_o && (lcd_byte_o == LcdHome)), "home command must follow clear")
  `DLB_ASSERT(a_last_is_m, (strobe_o && last_byte_o) |-> (is_data_o && (lcd_byte_o == CharM)), "last byte must be data M")

endmodule
